### design/radix_digit_reversal_assert.svh
// ----------------------------------------------------------------------------
// radix digit reversal assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_REVERSAL_ASSERT_SVH
`define RADIX_DIGIT_REVERSAL_ASSERT_SVH
`ifndef SYNTHESIS
`define RDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdr same-cycle check failed");
`define RDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdr next-cycle check failed");
`else
`define RDR_ASSERT_IMP(lbl, ante, cons)
`define RDR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg
// shared constants and types of the radix digit reversal block
// ----------------------------------------------------------------------------
package rdr_pkg;

    localparam int IN_BITS         = 63;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int RADIX_BITS      = 9;
    localparam int COUNT_BITS      = 7;
    localparam int DIV_CNT_BITS    = $clog2(IN_BITS);
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;
    localparam int REG_IDX_BITS    = APB_ADDR_BITS - 2;

    localparam logic [RADIX_BITS-1:0]   RADIX_RESET = 9'd10;
    localparam logic [RADIX_BITS-1:0]   RADIX_MIN   = 9'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_RADIX   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // divider outputs: done pulse plus held quotient and remainder
    typedef struct packed {
        logic                  done;
        logic [IN_BITS-1:0]    quot;
        logic [RADIX_BITS-1:0] rem;
    } t_div_res;

endpackage

### design/rdr_div.sv
// ----------------------------------------------------------------------------
// rdr_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rdr_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rdr_pkg::IN_BITS-1:0]     i_dividend,
    input  logic [rdr_pkg::RADIX_BITS-1:0]  i_divisor,
    output rdr_pkg::t_div_res               o_res
);

    logic [rdr_pkg::IN_BITS-1:0]      r_q, n_q;
    logic [rdr_pkg::RADIX_BITS-1:0]   r_rem, n_rem;
    logic [rdr_pkg::RADIX_BITS-1:0]   r_div;
    logic [rdr_pkg::DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                             r_busy, n_busy;
    logic                             r_done, n_done;

    logic [rdr_pkg::RADIX_BITS:0]     w_trial;
    logic [rdr_pkg::RADIX_BITS:0]     w_diff;
    logic                             w_ge;
    logic                             w_last;

    assign w_trial = {r_rem, r_q[rdr_pkg::IN_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_last  = (r_cnt == rdr_pkg::DIV_CNT_BITS'(rdr_pkg::IN_BITS - 1));

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so nine bits hold it
            n_rem = w_ge ? w_diff[rdr_pkg::RADIX_BITS-1:0]
                         : w_trial[rdr_pkg::RADIX_BITS-1:0];
            n_q   = {r_q[rdr_pkg::IN_BITS-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;
    assign o_res.rem  = r_rem;

endmodule

### design/rdr_mac.sv
// ----------------------------------------------------------------------------
// rdr_mac
// multiply-accumulate of digits with sticky overflow flag
// ----------------------------------------------------------------------------
module rdr_mac #(
    parameter int VALUE_BITS = rdr_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic                            i_step,
    input  logic [rdr_pkg::RADIX_BITS-1:0]  i_digit,
    input  logic [rdr_pkg::RADIX_BITS-1:0]  i_radix,
    output logic [VALUE_BITS-1:0]           o_acc,
    output logic                            o_ovf
);

    localparam int PROD_BITS = VALUE_BITS + rdr_pkg::RADIX_BITS + 1;

    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic [PROD_BITS-1:0]  w_prod;

    // low bits of acc*r+d stay exact even after the true value has overflowed
    assign w_prod = PROD_BITS'(r_acc) * PROD_BITS'(i_radix) + PROD_BITS'(i_digit);

    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        if (i_clear) begin
            n_acc = '0;
            n_ovf = 1'b0;
        end else if (i_step) begin
            n_acc = w_prod[VALUE_BITS-1:0];
            n_ovf = r_ovf | (w_prod[PROD_BITS-1:VALUE_BITS] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else begin
            r_ovf <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
    assign o_ovf = r_ovf;

endmodule

### design/radix_digit_reversal.sv
// ----------------------------------------------------------------------------
// radix_digit_reversal
// reverses the digits of an integer in a programmable radix
// ----------------------------------------------------------------------------
// D is the digit count (up to 63); a zero input skips the divider and goes
// straight to the final state, else the divider makes one pass per digit (63
// shift steps); a new input is taken only after the last result is loaded, input
// ready only while the sequencer is idle, and a stalled result holds it in the
// final state
// reset: synchronous active low, radix returns to 10, no result pending
// ----------------------------------------------------------------------------
`include "radix_digit_reversal_assert.svh"

module radix_digit_reversal #(
    parameter int VALUE_BITS = rdr_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rdr_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [rdr_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [rdr_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rdr_pkg::IN_BITS-1:0]         i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [VALUE_BITS-1:0]               o_reversed,
    output logic [rdr_pkg::COUNT_BITS-1:0]      o_digit_count,
    output logic                                o_overflowed
);

    rdr_pkg::t_state                    r_state, n_state;
    logic [rdr_pkg::RADIX_BITS-1:0]     r_radix;
    logic [rdr_pkg::COUNT_BITS-1:0]     r_count, n_count;
    logic                               r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]              r_reversed;
    logic [rdr_pkg::COUNT_BITS-1:0]     r_out_count;
    logic                               r_overflowed;

    logic [rdr_pkg::RADIX_BITS-1:0]     w_radix_eff;
    logic [rdr_pkg::REG_IDX_BITS-1:0]   w_reg_idx;
    logic                               w_cfg_wr;
    logic                               w_in_acc;
    logic                               w_div_start;
    logic [rdr_pkg::IN_BITS-1:0]        w_dividend;
    logic                               w_mac_step;
    logic                               w_load;
    logic [VALUE_BITS-1:0]              w_acc;
    logic                               w_ovf;
    rdr_pkg::t_div_res                  w_div;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[rdr_pkg::APB_ADDR_BITS-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = (w_reg_idx == rdr_pkg::REG_RADIX)
                     ? rdr_pkg::APB_DATA_BITS'(r_radix) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rdr_pkg::RADIX_RESET;
        end else if (w_cfg_wr && (w_reg_idx == rdr_pkg::REG_RADIX)) begin
            r_radix <= pwdata[rdr_pkg::RADIX_BITS-1:0];
        end
    end

    // radix 0 and 1 behave as 2
    assign w_radix_eff = (r_radix < rdr_pkg::RADIX_MIN) ? rdr_pkg::RADIX_MIN : r_radix;

    assign o_ready  = (r_state == rdr_pkg::S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_load   = (r_state == rdr_pkg::S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        w_div_start = 1'b0;
        w_dividend  = w_div.quot;
        w_mac_step  = 1'b0;
        unique case (r_state)
            rdr_pkg::S_IDLE: begin
                w_dividend = i_value;
                if (w_in_acc) begin
                    n_count = '0;
                    if (i_value == '0) begin
                        n_state = rdr_pkg::S_FIN;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = rdr_pkg::S_DIV;
                    end
                end
            end
            rdr_pkg::S_DIV: begin
                // the low digit comes out first and enters the accumulator first
                if (w_div.done) begin
                    w_mac_step = 1'b1;
                    n_count    = r_count + 1'b1;
                    if (w_div.quot != '0) begin
                        w_div_start = 1'b1;
                    end else begin
                        n_state = rdr_pkg::S_FIN;
                    end
                end
            end
            rdr_pkg::S_FIN: begin
                if (w_load) begin
                    n_state = rdr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rdr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdr_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_reversed   <= w_acc;
            r_out_count  <= r_count;
            r_overflowed <= w_ovf;
        end
    end

    rdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_radix_eff),
        .o_res      (w_div)
    );

    rdr_mac #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_in_acc),
        .i_step  (w_mac_step),
        .i_digit (w_div.rem),
        .i_radix (w_radix_eff),
        .o_acc   (w_acc),
        .o_ovf   (w_ovf)
    );

    assign o_valid       = r_out_valid;
    assign o_reversed    = r_reversed;
    assign o_digit_count = r_out_count;
    assign o_overflowed  = r_overflowed;

    `RDR_ASSERT_IMP(a_done_in_div, w_div.done, r_state == rdr_pkg::S_DIV)
    `RDR_ASSERT_NXT(a_zero_to_fin, w_in_acc && (i_value == '0), r_state == rdr_pkg::S_FIN)
    `RDR_ASSERT_IMP(a_count_max, 1'b1, r_count <= rdr_pkg::COUNT_BITS'(rdr_pkg::IN_BITS))
    `RDR_ASSERT_NXT(a_load_shows, w_load, r_out_valid && (r_state == rdr_pkg::S_IDLE))

endmodule

### bench/rdr_checker.sv
// ----------------------------------------------------------------------------
// rdr_checker
// watches the radix register writes and both streaming channels of the radix
// digit reversal block, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module rdr_checker
    import rdr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [APB_ADDR_BITS-1:0] i_paddr,
    input  logic [APB_DATA_BITS-1:0] i_pwdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [IN_BITS-1:0]       i_in_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [VALUE_BITS_DEF-1:0] i_reversed,
    input  logic [COUNT_BITS-1:0]    i_digit_count,
    input  logic                     i_overflowed,
    output int                       o_fail_count,
    output int                       o_outstanding,
    output int                       o_result_count,
    output int                       o_overflow_count
);

    typedef struct {
        logic [VALUE_BITS_DEF-1:0] reversed;
        logic [COUNT_BITS-1:0]     digit_count;
        logic                      overflowed;
    } t_reversal;

    t_reversal             expected_q[$];
    t_reversal             want;
    logic [RADIX_BITS-1:0] radix_q;
    int                    fails;
    int                    results;
    int                    overflows;

    // reverse the radix digits of one value, result kept modulo 2^VALUE_BITS
    function automatic t_reversal digit_reverse(logic [IN_BITS-1:0] value,
                                                logic [RADIX_BITS-1:0] radix);
        logic [63:0] digits[64];
        logic [63:0] rest;
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] mask;
        int          count;
        logic        ovf;
        t_reversal   res;
        rest  = 64'(value);
        base  = (radix < RADIX_MIN) ? 64'(RADIX_MIN) : 64'(radix);
        mask  = {64{1'b1}} >> (64 - VALUE_BITS_DEF);
        count = 0;
        acc   = '0;
        ovf   = 1'b0;
        while (rest != 0 && count < 64) begin
            digits[count] = rest % base;
            rest          = rest / base;
            count++;
        end
        // lowest digit of the input lands in the highest position
        for (int i = 0; i < count; i++) begin
            if (!ovf && acc > (mask - digits[i]) / base)
                ovf = 1'b1;
            acc = acc * base + digits[i];
        end
        res.reversed    = acc & mask;
        res.digit_count = count[COUNT_BITS-1:0];
        res.overflowed  = ovf;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_q = RADIX_RESET;
            expected_q.delete();
            fails     = 0;
            results   = 0;
            overflows = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[APB_ADDR_BITS-1:2] == REG_RADIX) begin
                radix_q = i_pwdata[RADIX_BITS-1:0];
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(digit_reverse(i_in_value, radix_q));
            if (i_out_valid && i_out_ready) begin
                results++;
                if (i_overflowed)
                    overflows++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: reversed %h digit_count %0d",
                           i_reversed, i_digit_count);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_reversed !== want.reversed) begin
                        $error("reversed: expected %h, got %h", want.reversed, i_reversed);
                        fails++;
                    end
                    if (i_digit_count !== want.digit_count) begin
                        $error("digit_count: expected %0d, got %0d",
                               want.digit_count, i_digit_count);
                        fails++;
                    end
                    if (i_overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0b, got %0b",
                               want.overflowed, i_overflowed);
                        fails++;
                    end
                end
            end
        end
        o_fail_count     <= fails;
        o_outstanding    <= expected_q.size();
        o_result_count   <= results;
        o_overflow_count <= overflows;
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives the radix digit reversal block through a short directed list and
// random phases under many radix settings, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb;
    import rdr_pkg::*;

    // slowest run: ~140 items of 63 digits each plus stalls, with a fivefold margin
    localparam int LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 12;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 1'b1;
    localparam logic [IN_BITS-1:0] MAX_VALUE = {IN_BITS{1'b1}};

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      i_valid;
    logic                      o_ready;
    logic [IN_BITS-1:0]        i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic [VALUE_BITS_DEF-1:0] o_reversed;
    logic [COUNT_BITS-1:0]     o_digit_count;
    logic                      o_overflowed;

    int fail_count;
    int outstanding;
    int result_count;
    int overflow_count;
    int cycles;
    int values_sent;
    int radix_writes;
    bit send_calm;
    bit take_calm;

    logic [RADIX_BITS-1:0] radix_plan[8] = '{9'd2, 9'd511, 9'd0, 9'd5,
                                             9'd256, 9'd1, 9'd257, 9'd7};
    logic [RADIX_BITS-1:0] phase_radix;

    radix_digit_reversal i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_reversed    (o_reversed),
        .o_digit_count (o_digit_count),
        .o_overflowed  (o_overflowed)
    );

    rdr_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_in_value       (i_value),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_reversed       (o_reversed),
        .i_digit_count    (o_digit_count),
        .i_overflowed     (o_overflowed),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_result_count   (result_count),
        .o_overflow_count (overflow_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    // stall length per transaction, with calm stretches of no stalls at all
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 11) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [IN_BITS-1:0] make_value(logic [RADIX_BITS-1:0] radix);
        logic [63:0] base;
        logic [63:0] v;
        logic [63:0] d;
        int          ndig;
        int          zeros;
        base = (radix < RADIX_MIN) ? 64'(RADIX_MIN) : 64'(radix);
        case ($urandom_range(0, 9))
            0: return IN_BITS'($urandom_range(0, 3 * int'(base)));
            1: return $urandom_range(0, 1) ? MAX_VALUE : {1'b1, {(IN_BITS-1){1'b0}}};
            2, 3: begin
                // digit by digit, then up to three zero digits appended where they fit
                ndig  = $urandom_range(1, 64);
                zeros = $urandom_range(0, 3);
                v     = '0;
                for (int i = 0; i < ndig; i++) begin
                    d = 64'($urandom_range(0, int'(base) - 1));
                    if (v > (64'(MAX_VALUE) - d) / base)
                        break;
                    v = v * base + d;
                end
                for (int i = 0; i < zeros; i++) begin
                    if (v <= 64'(MAX_VALUE) / base)
                        v = v * base;
                end
                return v[IN_BITS-1:0];
            end
            default: return IN_BITS'({$urandom, $urandom} >> $urandom_range(0, 62));
        endcase
    endfunction

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [RADIX_BITS-1:0] val);
        logic [APB_DATA_BITS-RADIX_BITS-1:0] junk;
        junk = (APB_DATA_BITS-RADIX_BITS)'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_radix(logic [RADIX_BITS-1:0] radix);
        wait_idle();
        write_reg(REG_RADIX, radix);
        phase_radix = radix;
        radix_writes++;
    endtask

    task automatic send_value(logic [IN_BITS-1:0] value);
        int gap;
        gap = draw_gap(send_calm);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        values_sent++;
    endtask

    // result side: stall a random number of cycles once a result shows up
    initial begin
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap(take_calm);
            if (gap != 0) begin
                i_ready <= 1'b0;
                do @(posedge i_clk); while (!o_valid);
                repeat (gap - 1) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_valid      <= 1'b0;
        i_value      <= '0;
        values_sent  = 0;
        radix_writes = 0;
        send_calm    = 1'b0;
        take_calm    = 1'b0;
        phase_radix  = RADIX_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // radix left at its reset value
        send_value('0);
        send_value(63'd1);
        send_value(63'd9);
        send_value(63'd1200);
        send_value(63'd12321);
        send_value(MAX_VALUE);

        // radix 0 and 1 both act as two
        set_radix(9'd0);
        send_value(63'd6);
        send_value(MAX_VALUE);
        set_radix(9'd1);
        send_value({1'b1, {(IN_BITS-1){1'b0}}});

        // radix above 256
        set_radix(9'd511);
        send_value(MAX_VALUE);
        send_value(63'd510);
        set_radix(9'd257);
        send_value(63'd66052);

        set_radix(9'd256);
        send_value(MAX_VALUE);
        send_value(63'h100);

        // write to the unused register must leave radix at 256
        wait_idle();
        write_reg(REG_SPARE, 9'd3);
        send_value(63'h1234);

        set_radix(9'd7);
        send_value(MAX_VALUE);
        send_value(63'd343);

        for (int p = 0; p < PHASES; p++) begin
            set_radix((p < 8) ? radix_plan[p] : RADIX_BITS'($urandom_range(0, 511)));
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if ($urandom_range(0, 24) == 0)
                    wait_idle();
                send_value(make_value(phase_radix));
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d values under %0d radix writes plus reset radix, incl. 0, 1, 256+",
                 values_sent, radix_writes);
        $display("checked %0d results, %0d of them overflowed", result_count, overflow_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### radix_digit_reversal.f
+incdir+design
design/rdr_pkg.sv
design/rdr_div.sv
design/rdr_mac.sv
design/radix_digit_reversal.sv
bench/rdr_checker.sv
bench/tb.sv
